FILE: rtl/core/crsf_pkg.sv
package crsf_pkg;

	localparam int FRAME_MAX = 64;
	localparam int LEN_W     = 7;
	localparam int POS_W     = $clog2(FRAME_MAX);
	localparam int RAM_AW    = POS_W + 1;
	localparam int RAM_DEPTH = 2 ** RAM_AW;

	localparam logic [7:0] CRC_POLY = 8'hD5;
	localparam logic [7:0] LEN_MIN  = 8'd2;
	localparam logic [7:0] LEN_MAX  = 8'(FRAME_MAX);

	typedef enum logic [1:0] {
		F_SYNC,
		F_LEN,
		F_DATA
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_SHOW
	} back_state_t;

	// descriptor of a validated frame waiting to be emitted
	typedef struct packed {
		logic             bsel;
		logic [LEN_W-1:0] len;
	} desc_t;

	typedef struct packed {
		logic valid;
		logic bsel;
	} done_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/crsf_ram.sv
module crsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/crsf_front.sv
module crsf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [7:0]                   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   rx_byte,
	output logic                         mem_we,
	output logic [crsf_pkg::RAM_AW-1:0] mem_waddr,
	output logic [7:0]                   mem_wdata,
	output logic                         push,
	output crsf_pkg::desc_t              push_desc,
	input  crsf_pkg::done_t              done
);
	import crsf_pkg::*;

	front_state_t     state_q, state_d;
	logic [7:0]       sync_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] wpos_q;
	logic [7:0]       crc_q;
	logic             wbuf_q;
	logic [1:0]       busy_q;
	logic             accept;
	logic             len_ok;
	logic             last_byte;

	assign accept    = in_valid && !in_stall;
	assign len_ok    = (rx_byte >= LEN_MIN) && (rx_byte <= LEN_MAX);
	assign last_byte = (rem_q == LEN_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_SYNC: begin
				if (accept && rx_byte == sync_q) begin
					state_d = F_LEN;
				end
			end
			F_LEN: begin
				if (accept) begin
					state_d = len_ok ? F_DATA : F_SYNC;
				end
			end
			F_DATA: begin
				if (accept && last_byte) begin
					state_d = F_SYNC;
				end
			end
			default: state_d = F_SYNC;
		endcase
	end

	always_comb begin
		in_stall = 1'b0;
		mem_we   = 1'b0;
		push     = 1'b0;
		unique case (state_q) inside
			F_SYNC, F_LEN: begin
				in_stall = 1'b0;
			end
			F_DATA: begin
				// buffer still being emitted by the back end
				in_stall = busy_q[wbuf_q];
				mem_we   = accept;
				push     = accept && last_byte && (crc_q == rx_byte);
			end
			default: in_stall = 1'b0;
		endcase
	end

	assign mem_waddr      = {wbuf_q, wpos_q[POS_W-1:0]};
	assign mem_wdata      = rx_byte;
	assign push_desc.bsel = wbuf_q;
	assign push_desc.len  = wpos_q + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_SYNC;
			sync_q  <= 8'd200;
			rem_q   <= '0;
			wpos_q  <= '0;
			crc_q   <= '0;
			wbuf_q  <= 1'b0;
			busy_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sync_q <= cfg_wdata;
			end
			if (accept && state_q == F_LEN && len_ok) begin
				rem_q  <= rx_byte[LEN_W-1:0];
				wpos_q <= '0;
				crc_q  <= '0;
			end
			if (accept && state_q == F_DATA) begin
				rem_q  <= rem_q - LEN_W'(1);
				wpos_q <= wpos_q + LEN_W'(1);
				if (!last_byte) begin
					crc_q <= crc8_update(crc_q, rx_byte);
				end
			end
			if (push) begin
				wbuf_q <= ~wbuf_q;
			end
			for (int b = 0; b < 2; b++) begin
				if (push && wbuf_q == 1'(b)) begin
					busy_q[b] <= 1'b1;
				end else if (done.valid && done.bsel == 1'(b)) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/core/crsf_dq.sv
module crsf_dq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  crsf_pkg::desc_t push_desc,
	input  logic            pop,
	output crsf_pkg::desc_t head,
	output logic            empty,
	output logic            full
);
	import crsf_pkg::*;

	desc_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule

FILE: rtl/core/crsf_back.sv
module crsf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  crsf_pkg::desc_t              q_head,
	output logic                         pop,
	output logic                         mem_re,
	output logic [crsf_pkg::RAM_AW-1:0] mem_raddr,
	input  logic [7:0]                   mem_rdata,
	output crsf_pkg::done_t              done,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   frame_byte,
	output logic [5:0]                   byte_index,
	output logic [6:0]                   frame_length,
	output logic                         last
);
	import crsf_pkg::*;

	back_state_t      state_q, state_d;
	desc_t            cur_q;
	logic [LEN_W-1:0] idx_q;
	logic             is_last;
	logic             taken;

	assign is_last = (idx_q == cur_q.len - LEN_W'(1));
	assign taken   = out_valid && !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = B_READ;
				end
			end
			B_READ: state_d = B_SHOW;
			B_SHOW: begin
				if (taken) begin
					state_d = is_last ? B_IDLE : B_READ;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		mem_re    = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			B_IDLE: pop = !q_empty;
			B_READ: mem_re = 1'b1;
			B_SHOW: out_valid = 1'b1;
			default: out_valid = 1'b0;
		endcase
	end

	assign mem_raddr    = {cur_q.bsel, idx_q[POS_W-1:0]};
	assign done.valid   = taken && is_last;
	assign done.bsel    = cur_q.bsel;
	assign frame_byte   = mem_rdata;
	assign byte_index   = idx_q[5:0];
	assign frame_length = cur_q.len;
	assign last         = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cur_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cur_q <= q_head;
				idx_q <= '0;
			end else if (taken && !is_last) begin
				idx_q <= idx_q + LEN_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/crsf_frame_receiver.sv
// channel   direction  handshake           payload
// cfg       in         cfg_we              cfg_wdata (sync byte)
// in        in         in_valid/in_stall   rx_byte
// out       out        out_valid/out_stall frame_byte, byte_index, frame_length, last
//
// Input bytes are taken one per cycle while in_stall is low; a frame is checked as
// its last byte arrives. After a frame's descriptor is fetched from the queue, each
// validated byte is read from the buffer, then presented until out_stall is low.
// Two frame buffers: input stalls only when a new frame's data targets a buffer whose
// frame is not fully emitted. Reset clears control state; buffers need no clearing.
module crsf_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic [5:0] byte_index,
	output logic [6:0] frame_length,
	output logic       last
);
	import crsf_pkg::*;

	logic              mem_we;
	logic [RAM_AW-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [RAM_AW-1:0] mem_raddr;
	logic [7:0]        mem_rdata;
	logic              push;
	desc_t             push_desc;
	logic              pop;
	desc_t             q_head;
	logic              q_empty;
	logic              q_full;
	done_t             done;

	crsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.push      (push),
		.push_desc (push_desc),
		.done      (done)
	);

	crsf_dq u_dq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	crsf_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	crsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (pop),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.done         (done),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length),
		.last         (last)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("descriptor pushed into full queue");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_length >= 7'd2) && (frame_length <= 7'(FRAME_MAX)))
		else $error("frame length out of range on output");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (7'(byte_index) == frame_length - 7'd1))
		else $error("last flag not on final byte");

	a_gap_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !out_valid)
		else $error("output valid right after frame end");
`endif

endmodule
